### rtl/core/pjs_pkg.sv
// Shared types and codes for the priority job scheduler.
package pjs_pkg;

  localparam int unsigned NUM_W  = 16;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned STAT_W = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SERVE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SERVED   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

  typedef struct packed {
    logic [NUM_W-1:0]  number;
    logic [PRIO_W-1:0] prio;
    logic [DUR_W-1:0]  dur;
  } entry_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [NUM_W-1:0]  num;
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
  } result_t;

endpackage

### rtl/core/pjs_mem.sv
// Job table storage: one write port, one registered read port.
module pjs_mem #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]      waddr_i,
  input  pjs_pkg::entry_t                     wdata_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]      raddr_i,
  output pjs_pkg::entry_t                     rdata_o
);
  import pjs_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/pjs_ctrl.sv
// Sequencer: sorted insertion walk, head removal and timeline update.
module pjs_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             in_cmd_i,
  input  logic [pjs_pkg::PRIO_W-1:0]       in_prio_i,
  input  logic [pjs_pkg::DUR_W-1:0]        in_dur_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output pjs_pkg::result_t                 res_o,
  output logic                             we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   waddr_o,
  output pjs_pkg::entry_t                  wdata_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   raddr_o,
  input  pjs_pkg::entry_t                  rdata_i
);
  import pjs_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_SRD   = 3'd4;
  localparam logic [2:0] S_SERVE = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     occ_q, occ_d;
  logic [AW-1:0]     head_q, head_d;
  logic [NUM_W-1:0]  next_num_q, next_num_d;
  logic [TIME_W-1:0] elapsed_q, elapsed_d;
  logic [AW-1:0]     i_q, i_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [DUR_W-1:0]  dur_q, dur_d;
  result_t           res_q, res_d;

  logic [CW-1:0]     occ_m1;
  logic [AW-1:0]     wr_idx;
  logic [AW:0]       rd_sum, wr_sum;
  logic [TIME_W:0]   sum_start, sum_end;
  logic [TIME_W-1:0] t_start, t_end;
  logic              goes_behind;
  entry_t            new_entry;

  assign occ_m1 = occ_q - CW'(1);

  // logical position to physical slot, ring starting at head
  assign wr_idx = (state_q == S_PLACE) ? '0 : i_q + AW'(1);
  assign rd_sum = {1'b0, head_q} + {1'b0, i_q};
  assign wr_sum = {1'b0, head_q} + {1'b0, wr_idx};
  always_comb begin
    raddr_o = (rd_sum >= DEPTH_A) ? AW'(rd_sum - DEPTH_A) : rd_sum[AW-1:0];
    waddr_o = (wr_sum >= DEPTH_A) ? AW'(wr_sum - DEPTH_A) : wr_sum[AW-1:0];
  end

  assign new_entry = '{number: next_num_q, prio: prio_q, dur: dur_q};

  // stored job moves behind the new one
  assign goes_behind = (rdata_i.prio > prio_q) ||
                       ((rdata_i.prio == prio_q) && (rdata_i.dur <= dur_q));

  assign sum_start = {1'b0, elapsed_q} + (TIME_W+1)'(1);
  assign sum_end   = {1'b0, elapsed_q} + (TIME_W+1)'(rdata_i.dur);
  assign t_start   = sum_start[TIME_W] ? '1 : sum_start[TIME_W-1:0];
  assign t_end     = sum_end[TIME_W]   ? '1 : sum_end[TIME_W-1:0];

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    head_d     = head_q;
    next_num_d = next_num_q;
    elapsed_d  = elapsed_q;
    i_d        = i_q;
    prio_d     = prio_q;
    dur_d      = dur_q;
    res_d      = res_q;
    we_o       = 1'b0;
    wdata_o    = new_entry;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          prio_d = in_prio_i;
          dur_d  = in_dur_i;
          if (in_cmd_i == CMD_INSERT) begin
            if (occ_q == DEPTH_C) begin
              res_d   = '{status: STAT_FULL, num: '0, t_start: '0, t_end: '0};
              state_d = S_OUT;
            end else if (occ_q == '0) begin
              state_d = S_PLACE;
            end else begin
              i_d     = occ_m1[AW-1:0];
              state_d = S_READ;
            end
          end else begin
            if (occ_q == '0) begin
              res_d   = '{status: STAT_EMPTY, num: '0, t_start: '0, t_end: '0};
              state_d = S_OUT;
            end else begin
              i_d     = '0;
              state_d = S_SRD;
            end
          end
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        we_o = 1'b1;
        if (goes_behind) begin
          wdata_o = rdata_i;
          if (i_q == '0) begin
            state_d = S_PLACE;
          end else begin
            i_d     = i_q - AW'(1);
            state_d = S_READ;
          end
        end else begin
          occ_d      = occ_q + CW'(1);
          next_num_d = next_num_q + NUM_W'(1);
          res_d      = '{status: STAT_INSERTED, num: next_num_q, t_start: '0, t_end: '0};
          state_d    = S_OUT;
        end
      end
      S_PLACE: begin
        we_o       = 1'b1;
        occ_d      = occ_q + CW'(1);
        next_num_d = next_num_q + NUM_W'(1);
        res_d      = '{status: STAT_INSERTED, num: next_num_q, t_start: '0, t_end: '0};
        state_d    = S_OUT;
      end
      S_SRD: begin
        state_d = S_SERVE;
      end
      S_SERVE: begin
        occ_d     = occ_m1;
        head_d    = (head_q == LAST_A) ? '0 : head_q + AW'(1);
        elapsed_d = t_end;
        res_d     = '{status: STAT_SERVED, num: rdata_i.number,
                      t_start: t_start, t_end: t_end};
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      occ_q      <= '0;
      head_q     <= '0;
      next_num_q <= NUM_W'(1);
      elapsed_q  <= '0;
    end else begin
      state_q    <= state_d;
      occ_q      <= occ_d;
      head_q     <= head_d;
      next_num_q <= next_num_d;
      elapsed_q  <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    prio_q <= prio_d;
    dur_q  <= dur_d;
    res_q  <= res_d;
  end

endmodule

### rtl/core/priority_job_scheduler_top.sv
// Top level of the priority job scheduler: stream ports and output register.
//
//  channel  | direction | tdata (low bit first)                    | tuser
//  ---------+-----------+------------------------------------------+---------
//  s_axis   | in        | job_priority[7:0], job_duration[15:0]    | cmd
//  m_axis   | out       | served_job[15:0], start_time, end_time   | status
//
// From accept until ready again: an insert walks the table from the tail, reading each
// stored job and moving it back one slot while it goes behind the new job, then writes
// the new job; a full table reports full with no walk. A serve reads the head job, an
// empty table reports empty. The single read port splits each walk step: read, compare.
// Reset clears the table to empty; stored entries need no clearing.
// A result waits in the output register while the next job is accepted.
module priority_job_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // job_priority[7:0], job_duration[23:8]
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // served_job[15:0], start_time[47:16], end_time[79:48]
  output logic [1:0]  m_axis_tuser   // status
);
  import pjs_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  logic          res_valid, res_ready;
  result_t       res;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  logic          out_valid_q;
  result_t       out_q;

  pjs_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pjs_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_prio_i   (s_axis_tdata[7:0]),
    .in_dur_i    (s_axis_tdata[23:8]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {out_q.t_end, out_q.t_start, out_q.num};

endmodule

### tb/priority_job_scheduler_top_tb.sv
// Self-checking testbench for the priority job scheduler stream top level.
`timescale 1ns / 100ps

module priority_job_scheduler_top_tb;
  import pjs_pkg::*;

  localparam int unsigned Q_DEPTH      = 16;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam longint unsigned CYCLE_LIMIT = 64'd5_000_000;
  // back-to-back insert/serve pairs of full-length jobs
  localparam int unsigned LONG_PAIRS   = 12;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;  // job_priority[7:0], job_duration[23:8]
  logic        s_axis_tuser;  // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;  // served_job[15:0], start_time[47:16], end_time[79:48]
  logic [1:0]  m_axis_tuser;  // status

  // scheduler state as the checker sees it
  entry_t      sched_table[$];
  logic [15:0] next_job_num = 16'd1;
  logic [31:0] timeline     = '0;
  result_t     expected_results[$];

  int unsigned     err_cnt       = 0;
  int unsigned     hold_requests = 0;
  bit              src_idle_en   = 1'b0;
  bit              sink_idle_en  = 1'b0;
  longint unsigned cycle_cnt     = 0;

  priority_job_scheduler_top #(
    .QUEUE_DEPTH(Q_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sorted insert / head removal on a saturating timeline.
  function automatic result_t sched_predict(input logic cmd, input logic [7:0] prio,
                                            input logic [15:0] dur);
    result_t     r;
    entry_t      ent;
    entry_t      head;
    int unsigned pos;
    logic [32:0] sum;
    r = '0;
    if (cmd == CMD_INSERT) begin
      if (sched_table.size() >= Q_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        pos = 0;
        // skip jobs of lower priority value, and longer jobs of equal priority
        while (pos < sched_table.size() &&
               (sched_table[pos].prio < prio ||
                (sched_table[pos].prio == prio && sched_table[pos].dur > dur)))
          pos++;
        ent.number = next_job_num;
        ent.prio   = prio;
        ent.dur    = dur;
        sched_table.insert(pos, ent);
        r.status     = STAT_INSERTED;
        r.num        = next_job_num;
        next_job_num = next_job_num + 16'd1;
      end
    end else begin
      if (sched_table.size() == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        head      = sched_table.pop_front();
        r.status  = STAT_SERVED;
        r.num     = head.number;
        sum       = {1'b0, timeline} + 33'd1;
        r.t_start = sum[32] ? '1 : sum[31:0];
        sum       = {1'b0, timeline} + {17'd0, head.dur};
        r.t_end   = sum[32] ? '1 : sum[31:0];
        timeline  = r.t_end;
      end
    end
    return r;
  endfunction

  task automatic send_cmd(input logic cmd, input logic [7:0] prio, input logic [15:0] dur);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {dur, prio};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(sched_predict(cmd, prio, dur));
  endtask

  // valid is left high after a transfer; anything that pauses the source drops it
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    err_cnt++;
    $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result: expected none, actual status %0d tdata 0x%0h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", want.status, m_axis_tuser);
        if (m_axis_tdata[15:0] !== want.num)
          report_mismatch("served_job", want.num, m_axis_tdata[15:0]);
        if (m_axis_tdata[47:16] !== want.t_start)
          report_mismatch("start_time", want.t_start, m_axis_tdata[47:16]);
        if (m_axis_tdata[79:48] !== want.t_end)
          report_mismatch("end_time", want.t_end, m_axis_tdata[79:48]);
      end
    end
  end

  // result side ready: random stalls plus a long hold on request
  initial begin : sink_ready
    int unsigned stall_left;
    int unsigned hold_done;
    stall_left    = 0;
    hold_done     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_done != hold_requests) begin
        hold_done  = hold_requests;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && sink_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ties, lengths either side, priorities between stored ones, zero duration
  task automatic test_directed();
    int unsigned k;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_cmd(CMD_SERVE, 8'hFF, 16'hFFFF);  // empty table
    send_cmd(CMD_INSERT, 8'd10, 16'd100);
    send_cmd(CMD_INSERT, 8'd10, 16'd100);  // equal job goes ahead
    send_cmd(CMD_INSERT, 8'd10, 16'd200);
    send_cmd(CMD_INSERT, 8'd10, 16'd50);
    send_cmd(CMD_INSERT, 8'd5, 16'd0);
    send_cmd(CMD_INSERT, 8'd255, 16'hFFFF);
    send_cmd(CMD_INSERT, 8'd0, 16'hFFFF);
    send_cmd(CMD_INSERT, 8'd7, 16'd1);     // between stored priorities
    send_cmd(CMD_INSERT, 8'd200, 16'd0);
    for (k = 0; k < 10; k++)
      send_cmd(CMD_SERVE, 8'(k), 16'(k));
    wait_drained();
  endtask

  task automatic test_full_table();
    int unsigned k;
    for (k = 0; k < Q_DEPTH + 2; k++)
      send_cmd(CMD_INSERT, 8'($urandom_range(0, 3)), 16'($urandom));
    for (k = 0; k < Q_DEPTH + 1; k++)
      send_cmd(CMD_SERVE, 8'($urandom), 16'($urandom));
    wait_drained();
  endtask

  // output held off while jobs keep coming, then source waits for all results
  task automatic test_output_stall();
    int unsigned k;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_requests++;
    for (k = 0; k < 12; k++)
      send_cmd((k % 3 == 2) ? CMD_SERVE : CMD_INSERT, 8'($urandom_range(0, 7)),
               16'($urandom));
    wait_drained();
  endtask

  task automatic test_random_mix();
    int unsigned blk;
    int unsigned k;
    int unsigned ins_pct;
    logic        cmd;
    logic [7:0]  prio;
    logic [15:0] dur;
    for (blk = 0; blk < 19; blk++) begin
      case ($urandom_range(0, 3))
        0:       ins_pct = 25;
        1:       ins_pct = 50;
        2:       ins_pct = 70;
        default: ins_pct = 90;
      endcase
      // the tail blocks run without idling
      src_idle_en  = (blk < 16) && ($urandom_range(0, 3) != 0);
      sink_idle_en = (blk < 16) && ($urandom_range(0, 3) != 0);
      for (k = 0; k < 50; k++) begin
        cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_SERVE;
        case ($urandom_range(0, 3))
          0, 1:    prio = 8'($urandom_range(0, 3));
          2:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: prio = 8'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0, 1:    dur = 16'($urandom_range(0, 3));
          2:       dur = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: dur = 16'($urandom);
        endcase
        send_cmd(cmd, prio, dur);
      end
    end
  endtask

  // full-length jobs served back to back, then a zero duration job
  task automatic test_long_timeline();
    int unsigned k;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    while (sched_table.size() != 0)
      send_cmd(CMD_SERVE, 8'($urandom), 16'($urandom));
    for (k = 0; k < LONG_PAIRS; k++) begin
      send_cmd(CMD_INSERT, 8'($urandom), 16'hFFFF);
      send_cmd(CMD_SERVE, 8'($urandom), 16'($urandom));
    end
    send_cmd(CMD_INSERT, 8'd0, 16'd0);
    send_cmd(CMD_SERVE, 8'd0, 16'd0);
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_INSERT;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_table();
    test_output_stall();
    test_random_mix();
    test_long_timeline();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
